>>> rtl/lla_pkg.sv
package lla_pkg;

  localparam int unsigned CELL_W   = 3;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned CFG_DW   = 10;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned NBR_N    = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned MIN_SIZE = 3;

  localparam logic [CFG_DW-1:0] ROWS_RESET = 10'd400;
  localparam logic [CFG_DW-1:0] COLS_RESET = 10'd420;

  localparam logic [CFG_IW-1:0] CFG_RULE_SELECT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_AGE_MODE    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GRID_ROWS   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_GRID_COLS   = 2'd3;

  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [1:0] {
    RULE_LIFE   = 2'd0,
    RULE_CORAL  = 2'd1,
    RULE_AMOEBA = 2'd2,
    RULE_MAZE   = 2'd3
  } rule_t;

  typedef struct packed {
    rule_t rule;
    logic  age_mode;
  } rule_ctrl_t;

  // bit k set: k live neighbours give birth
  function automatic logic [NBR_N:0] birth_mask(input rule_t rule);
    logic [NBR_N:0] m;
    case (rule)
      RULE_LIFE:   m = 9'h008;
      RULE_CORAL:  m = 9'h008;
      RULE_AMOEBA: m = 9'h0A8;
      RULE_MAZE:   m = 9'h008;
      default:     m = 9'h008;
    endcase
    return m;
  endfunction

  // bit k set: k live neighbours keep a live cell alive
  function automatic logic [NBR_N:0] survive_mask(input rule_t rule);
    logic [NBR_N:0] m;
    case (rule)
      RULE_LIFE:   m = 9'h00C;
      RULE_CORAL:  m = 9'h1F0;
      RULE_AMOEBA: m = 9'h12A;
      RULE_MAZE:   m = 9'h03E;
      default:     m = 9'h00C;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/lla_line_mem.sv
module lla_line_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lla_cell_update.sv
module lla_cell_update #(
  parameter int unsigned AGE_LEVELS = 8
) (
  input  lla_pkg::rule_ctrl_t            ctrl,
  input  logic                           interior,
  input  lla_pkg::cell_t                 centre,
  input  logic [lla_pkg::NBR_N-1:0]      nbr_live,
  output lla_pkg::cell_t                 next_state
);

  localparam int unsigned AGE_W   = 9;
  localparam int unsigned AGE_TOP = AGE_LEVELS - 1;

  logic [lla_pkg::CNT_W-1:0] count;
  logic [lla_pkg::NBR_N:0]   mask;
  logic                      live;
  logic [AGE_W-1:0]          age;

  always_comb begin
    count = '0;
    for (int k = 0; k < lla_pkg::NBR_N; k++) begin
      count = count + lla_pkg::CNT_W'(nbr_live[k]);
    end
  end

  assign mask = (centre != '0) ? lla_pkg::survive_mask(ctrl.rule)
                               : lla_pkg::birth_mask(ctrl.rule);
  assign live = interior && mask[count];

  // saturating age; a newborn starts at one
  assign age = (AGE_W'(centre) >= AGE_W'(AGE_TOP)) ? AGE_W'(AGE_TOP)
                                                   : AGE_W'(centre) + AGE_W'(1);

  always_comb begin
    if (!live) begin
      next_state = '0;
    end else if (ctrl.age_mode) begin
      next_state = lla_pkg::CELL_W'(age);
    end else begin
      next_state = lla_pkg::cell_t'(1);
    end
  end

endmodule

>>> rtl/life_like_automaton_generation_top.sv
// Pipeline: an accepted cell is registered in stage 1, and its result in the output register.
// Throughput: one cell per cycle unless out_stall holds the output; the line store is
// read and written once per cell through a single-port-per-direction RAM, with a
// forwarding path for back-to-back accesses to the same column.
// Reset: synchronous, active low; clears control, window and a fill count that makes
// unwritten line store columns read as dead, so the block is ready at once.
module life_like_automaton_generation_top #(
  parameter int unsigned MAX_COLS   = 512,
  parameter int unsigned MAX_ROWS   = 512,
  parameter int unsigned AGE_LEVELS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lla_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lla_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lla_pkg::CELL_W-1:0]   in_cell_state,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lla_pkg::CELL_W-1:0]   out_next_state,
  output logic [lla_pkg::POS_W-1:0]    out_row,
  output logic [lla_pkg::POS_W-1:0]    out_col,
  output logic                         out_frame_done
);

  localparam int unsigned CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CSW0 = $clog2(MAX_COLS + 1);
  localparam int unsigned RSW0 = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW1  = (CSW0 > RSW0) ? CSW0 : RSW0;
  localparam int unsigned SW   = (SW1 > lla_pkg::CFG_DW) ? SW1 : lla_pkg::CFG_DW;
  localparam int unsigned LW   = 2 * lla_pkg::CELL_W;

  // configuration
  lla_pkg::rule_ctrl_t        ctrl_r;
  logic [lla_pkg::CFG_DW-1:0] grid_rows_r;
  logic [lla_pkg::CFG_DW-1:0] grid_cols_r;
  logic                       restart;

  // input position
  logic [RIW-1:0] in_row_r, in_row_nxt;
  logic [CIW-1:0] in_col_r, in_col_nxt;

  // stage 1
  logic                 s1_valid_r;
  lla_pkg::cell_t       s1_cell_r;
  logic [CIW-1:0]       s1_col_r;
  logic [RIW-1:0]       s1_lr_r;
  logic [CIW-1:0]       s1_lc_r;
  logic                 s1_interior_r;
  logic                 s1_done_r;
  logic                 fwd_r;
  logic [LW-1:0]        fwd_data_r;
  logic [CIW:0]         fill_r;

  // 3x3 window: left and centre columns kept, rows top to bottom
  lla_pkg::cell_t win_mid_r [3];
  lla_pkg::cell_t win_right_r [3];

  // output register
  logic           out_valid_r;
  lla_pkg::cell_t out_next_state_r;
  logic [lla_pkg::POS_W-1:0] out_row_r;
  logic [lla_pkg::POS_W-1:0] out_col_r;
  logic           out_done_r;

  logic accept, out_en, s1_fire;
  logic [SW-1:0] rows_ext, cols_ext, rows, cols;
  logic [SW-1:0] r0, c0, lr0, lc0;
  logic [RIW-1:0] r0_n;
  logic [CIW-1:0] c0_n;
  logic [LW-1:0] rd_data, line_q, wr_data;
  lla_pkg::cell_t up, mid, new_state;
  logic [lla_pkg::NBR_N-1:0] nbr_live;

  assign out_en   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_en;
  assign in_stall = s1_valid_r && !out_en;
  assign accept   = in_valid && !in_stall;

  // ---- configuration ----
  assign restart = cfg_wr_en &&
                   (cfg_index == lla_pkg::CFG_GRID_ROWS || cfg_index == lla_pkg::CFG_GRID_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.rule     <= lla_pkg::RULE_LIFE;
      ctrl_r.age_mode <= 1'b0;
      grid_rows_r     <= lla_pkg::ROWS_RESET;
      grid_cols_r     <= lla_pkg::COLS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lla_pkg::CFG_RULE_SELECT: ctrl_r.rule     <= lla_pkg::rule_t'(cfg_wdata[1:0]);
        lla_pkg::CFG_AGE_MODE:    ctrl_r.age_mode <= cfg_wdata[0];
        lla_pkg::CFG_GRID_ROWS:   grid_rows_r     <= cfg_wdata;
        lla_pkg::CFG_GRID_COLS:   grid_cols_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_ext = SW'(grid_rows_r);
  assign cols_ext = SW'(grid_cols_r);
  assign rows = (rows_ext < SW'(lla_pkg::MIN_SIZE)) ? SW'(lla_pkg::MIN_SIZE) :
                (rows_ext > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : rows_ext;
  assign cols = (cols_ext < SW'(lla_pkg::MIN_SIZE)) ? SW'(lla_pkg::MIN_SIZE) :
                (cols_ext > SW'(MAX_COLS)) ? SW'(MAX_COLS) : cols_ext;

  // ---- stage 0: position, lagged position, line store read ----
  assign r0   = (SW'(in_row_r) >= rows) ? '0 : SW'(in_row_r);
  assign c0   = (SW'(in_col_r) >= cols) ? '0 : SW'(in_col_r);
  assign r0_n = RIW'(r0);
  assign c0_n = CIW'(c0);

  always_comb begin
    if (c0 != '0) begin
      lc0 = c0 - SW'(1);
      lr0 = (r0 != '0) ? r0 - SW'(1) : rows - SW'(1);
    end else begin
      lc0 = cols - SW'(1);
      lr0 = (r0 >= SW'(2)) ? r0 - SW'(2) : r0 + rows - SW'(2);
    end
  end

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (restart) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (accept) begin
      if (c0 + SW'(1) >= cols) begin
        in_col_nxt = '0;
        in_row_nxt = (r0 + SW'(1) >= rows) ? '0 : RIW'(r0 + SW'(1));
      end else begin
        in_col_nxt = CIW'(c0 + SW'(1));
        in_row_nxt = r0_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  lla_line_mem #(
    .DEPTH (MAX_COLS),
    .AW    (CIW),
    .DW    (LW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c0_n),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell_r     <= in_cell_state;
      s1_col_r      <= c0_n;
      s1_lr_r       <= RIW'(lr0);
      s1_lc_r       <= CIW'(lc0);
      s1_interior_r <= (lr0 >= SW'(1)) && (lr0 + SW'(2) <= rows) &&
                       (lc0 >= SW'(1)) && (lc0 + SW'(2) <= cols);
      s1_done_r     <= (lr0 + SW'(2) == rows) && (lc0 + SW'(2) == cols);
      // same column written by the item leaving stage 1 at this edge
      fwd_r         <= s1_fire && (s1_col_r == c0_n);
      fwd_data_r    <= wr_data;
    end
  end

  // ---- stage 1: window, rule, write back ----
  // columns at or beyond the fill count were never written and read as dead
  assign line_q  = fwd_r ? fwd_data_r :
                   ((CIW+1)'(s1_col_r) < fill_r) ? rd_data : '0;
  assign up      = line_q[LW-1 -: lla_pkg::CELL_W];
  assign mid     = line_q[lla_pkg::CELL_W-1:0];
  assign wr_data = {mid, s1_cell_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (s1_fire && ((CIW+1)'(s1_col_r) == fill_r)) begin
      fill_r <= fill_r + (CIW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_mid_r[k]   <= '0;
        win_right_r[k] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_mid_r[k] <= win_right_r[k];
      end
      win_right_r[0] <= up;
      win_right_r[1] <= mid;
      win_right_r[2] <= s1_cell_r;
    end
  end

  assign nbr_live = {win_mid_r[0] != '0, win_mid_r[1] != '0, win_mid_r[2] != '0,
                     win_right_r[0] != '0, win_right_r[2] != '0,
                     up != '0, mid != '0, s1_cell_r != '0};

  lla_cell_update #(
    .AGE_LEVELS (AGE_LEVELS)
  ) u_cell_update (
    .ctrl       (ctrl_r),
    .interior   (s1_interior_r),
    .centre     (win_right_r[1]),
    .nbr_live   (nbr_live),
    .next_state (new_state)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_next_state_r <= new_state;
      out_row_r        <= lla_pkg::POS_W'(s1_lr_r);
      out_col_r        <= lla_pkg::POS_W'(s1_lc_r);
      out_done_r       <= s1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_state = out_next_state_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_done = out_done_r;

`ifndef NO_ASSERTIONS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted cell did not reach stage 1");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_en) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_cell_r)))
    else $error("stalled stage 1 changed");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("stage 1 item lost before output");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (CIW+1)'(MAX_COLS))
    else $error("line store fill count overran depth");
`endif

endmodule
